@@ hw/rtl/stet_pkg.sv @@
// ----------------------------------------------------------------------------
// stet_pkg: shared types and codes of the software timer event table
// Request codes, slot modes, the command that goes out to every cell and
// the report that the cells send back.
// ----------------------------------------------------------------------------
package stet_pkg;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_ADD     = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_SUSPEND = 3'd3;
    localparam logic [2:0] REQ_RESUME  = 3'd4;

    localparam logic [1:0] MODE_SINGLE   = 2'd0;
    localparam logic [1:0] MODE_REPEATED = 2'd1;
    localparam logic [1:0] MODE_CYCLED   = 2'd2;
    localparam logic [1:0] MODE_ABSOLUTE = 2'd3;

    typedef struct packed {
        logic [2:0]  req;
        logic [1:0]  mode;
        logic [31:0] dt;
        logic [15:0] reps;
        logic [4:0]  sid;
        logic [31:0] tick;
        logic [31:0] rtc;
    } t_cmd;

    typedef struct packed {
        logic fire;      // slot fired on this scan step
        logic freed;     // firing released the slot
        logic took;      // add claimed this slot
        logic was_used;  // remove hit a used slot
    } t_rep;

endpackage

@@ hw/rtl/software_timer_event_table.sv @@
// ----------------------------------------------------------------------------
// software_timer_event_table: table of timer slots driven by requests
// Row of slot cells, a scan sequencer and a registered result stream.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser = request type, tdata = add/slot/rtc
// fields); results leave on m_axis (tuser = fired flag, tlast = final
// result of the request). scheduler_enable is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce it. A tick or an add walks
// a token along the row of cells, one slot per cycle while the output is
// not stalled; remove, suspend and resume act on their slot directly. One
// request is handled at a time: s_axis_tready is high only between requests.
// A fired slot is held back until the next one fires or the scan ends, so
// that tlast can be set on the last one; the scan pauses while the output
// register is full and the receiver stalls. Reset frees all slots, clears
// the tick counter and sets scheduler_enable; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_event_table #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] req_type
    input  logic [2:0]  s_axis_tuser,
    // [1:0] entry_mode, [33:2] delay_or_time, [49:34] repeat_count,
    // [54:50] slot_id, [86:55] rtc_time, [87] zero
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] event_kind
    output logic        m_axis_tuser,
    // [4:0] out_slot, [9:5] free_slots, [15:10] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import stet_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIR  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state      r_state;
    logic        r_en;
    logic [2:0]  r_req;
    logic [1:0]  r_mode;
    logic [31:0] r_dt, r_tick, r_rtc;
    logic [15:0] r_reps;
    logic [4:0]  r_sid;
    logic [IW-1:0] r_idx;
    logic [FW-1:0] r_free, n_free, r_id, cur_slot;
    logic        r_pv;
    logic [FW-1:0] r_p_slot, r_p_free;
    logic        r_ov, r_okind, r_olast;
    logic [FW-1:0] r_oslot, r_ofree;

    t_cmd        cmd;
    t_rep        reps [SLOT_COUNT];
    t_rep        rep;
    logic [SLOT_COUNT:0] tok;
    logic        accept, ofree, step, load, kill, direct, final_step;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign ofree   = !r_ov || m_axis_tready;
    assign step    = (r_state == ST_SCAN) && ofree;
    assign load    = accept && ((s_axis_tuser == REQ_TICK && r_en) || s_axis_tuser == REQ_ADD);
    assign kill    = (r_state != ST_SCAN) && !load;
    assign direct  = (r_state == ST_DIR) && ofree;
    assign final_step = step && (r_idx == IW'(SLOT_COUNT - 1));
    assign cur_slot   = FW'(r_idx) + FW'(1);

    assign cmd = '{req: r_req, mode: r_mode, dt: r_dt, reps: r_reps, sid: r_sid,
                   tick: r_tick, rtc: r_rtc};
    assign tok[0] = load;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        stet_cell #(.IDX(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (tok[g]),
            .i_step   (step || load),
            .i_kill   (kill),
            .i_direct (direct),
            .i_cmd    (cmd),
            .o_tok    (tok[g+1]),
            .o_rep    (reps[g])
        );
    end

    always_comb begin
        rep = '0;
        for (int k = 0; k < SLOT_COUNT; k++) rep = rep | reps[k];
        n_free = r_free;
        if (rep.took) n_free = n_free - FW'(1);
        if (rep.freed || rep.was_used) n_free = n_free + FW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_en    <= 1'b1;
            r_tick  <= '0;
            r_free  <= FW'(SLOT_COUNT);
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_wr_en) r_en <= i_cfg_wr_data;
            r_free <= n_free;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_pv  <= 1'b0;
                        r_idx <= '0;
                        if (s_axis_tuser == REQ_TICK) r_tick <= r_tick + 32'd1;
                        if (load) r_state <= ST_SCAN;
                        else if (s_axis_tuser == REQ_REMOVE || s_axis_tuser == REQ_SUSPEND
                                 || s_axis_tuser == REQ_RESUME) r_state <= ST_DIR;
                        else r_state <= ST_FIN;
                    end
                end
                ST_SCAN: begin
                    if (step) begin
                        r_idx <= r_idx + IW'(1);
                        if (rep.fire) begin
                            r_pv <= 1'b1;
                            if (r_pv) r_ov <= 1'b1;
                        end
                        if (rep.took || final_step) r_state <= ST_FIN;
                    end
                end
                ST_DIR: begin
                    if (direct) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    if (ofree) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= s_axis_tuser;
            r_mode <= s_axis_tdata[1:0];
            r_dt   <= s_axis_tdata[33:2];
            r_reps <= s_axis_tdata[49:34];
            r_sid  <= s_axis_tdata[54:50];
            r_rtc  <= s_axis_tdata[86:55];
            r_id   <= '0;
        end
        if (step && rep.took) r_id <= cur_slot;
        if (step && rep.fire) begin
            r_p_slot <= cur_slot;
            r_p_free <= n_free;
            if (r_pv) begin
                r_okind <= 1'b1;
                r_oslot <= r_p_slot;
                r_ofree <= r_p_free;
                r_olast <= 1'b0;
            end
        end
        if (direct) begin
            r_okind <= 1'b0;
            r_oslot <= '0;
            r_ofree <= n_free;
            r_olast <= 1'b1;
        end
        if (r_state == ST_FIN && ofree) begin
            r_okind <= r_pv;
            r_oslot <= r_pv ? r_p_slot : r_id;
            r_ofree <= r_pv ? r_p_free : r_free;
            r_olast <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {6'd0, 5'(r_ofree), 5'(r_oslot)};

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(SLOT_COUNT))
        else $error("free count above slot count");
    a_token_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok[SLOT_COUNT:1]))
        else $error("more than one scan token");
    a_scan_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (tok[SLOT_COUNT:1] != '0))
        else $error("scan without token");
`endif

endmodule

@@ hw/rtl/stet_cell.sv @@
// ----------------------------------------------------------------------------
// stet_cell: one timer slot
// Holds the state of one slot. A scan token moves through the row of cells;
// the cell holding it acts on the broadcast command when the row steps.
// ----------------------------------------------------------------------------
module stet_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok,      // token from left neighbor
    input  logic            i_step,
    input  logic            i_kill,
    input  logic            i_direct,   // remove / suspend / resume strobe
    input  stet_pkg::t_cmd  i_cmd,
    output logic            o_tok,
    output stet_pkg::t_rep  o_rep
);
    import stet_pkg::*;

    logic        r_tok, r_used, r_active;
    logic        n_used, n_active;
    logic [1:0]  r_mode, n_mode;
    logic [31:0] r_dl, n_dl, r_rl, n_rl;
    logic [15:0] r_cyc, n_cyc;
    logic        sel, hit, match;

    assign sel   = r_tok && i_step;
    assign match = i_direct && (int'(i_cmd.sid) == IDX + 1);
    assign o_tok = r_tok;

    always_comb begin
        o_rep    = '0;
        n_used   = r_used;
        n_active = r_active;
        n_mode   = r_mode;
        n_dl     = r_dl;
        n_rl     = r_rl;
        n_cyc    = r_cyc;
        hit      = (r_mode == MODE_ABSOLUTE) ? (i_cmd.rtc >= r_dl) : (i_cmd.tick >= r_dl);
        if (sel && i_cmd.req == REQ_TICK && r_used && r_active && hit) begin
            o_rep.fire = 1'b1;
            unique case (r_mode)
                MODE_REPEATED: n_dl = i_cmd.tick + r_rl;
                MODE_CYCLED: begin
                    n_cyc = r_cyc - 16'd1;
                    if (n_cyc != 16'd0) begin
                        n_dl = i_cmd.tick + r_rl;
                    end else begin
                        n_used      = 1'b0;
                        o_rep.freed = 1'b1;
                    end
                end
                default: begin
                    n_used      = 1'b0;
                    o_rep.freed = 1'b1;
                end
            endcase
        end
        if (sel && i_cmd.req == REQ_ADD && !r_used) begin
            o_rep.took = 1'b1;
            n_used     = 1'b1;
            n_active   = 1'b1;
            n_mode     = i_cmd.mode;
            n_dl       = (i_cmd.mode == MODE_ABSOLUTE) ? i_cmd.dt : i_cmd.tick + i_cmd.dt;
            n_rl       = (i_cmd.mode == MODE_SINGLE) ? 32'd0 : i_cmd.dt;
            if (i_cmd.mode == MODE_CYCLED) n_cyc = i_cmd.reps;
        end
        if (match) begin
            if (i_cmd.req == REQ_REMOVE) begin
                o_rep.was_used = r_used;
                n_used         = 1'b0;
            end else if (i_cmd.req == REQ_SUSPEND) begin
                n_active = 1'b0;
            end else if (i_cmd.req == REQ_RESUME) begin
                n_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_used   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_kill)      r_tok <= 1'b0;
            else if (i_step) r_tok <= i_tok;
            r_used   <= n_used;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_dl   <= n_dl;
        r_rl   <= n_rl;
        r_cyc  <= n_cyc;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for software_timer_event_table
// Drives tick, add, remove, suspend, resume and unknown requests on the
// input stream, keeps its own copy of the slot table to predict every
// result, and checks each result transfer in order on the output stream.
// ----------------------------------------------------------------------------
module testbench;
    import stet_pkg::*;

    localparam int SLOTS = 16;

    typedef struct {
        logic [2:0]  req;
        logic [1:0]  mode;
        logic [31:0] dt;
        logic [15:0] reps;
        logic [4:0]  sid;
        logic [31:0] rtc;
    } t_request;

    typedef struct {
        logic       kind;
        logic [4:0] slot;
        logic [4:0] free;
        logic       last;
    } t_event;

    typedef struct {
        t_request rq;
        bit       typed;
        t_event   ev;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic        i_cfg_wr_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic        m_axis_tuser;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    software_timer_event_table #(.SLOT_COUNT(SLOTS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow slot table
    logic [31:0] tick_cnt;
    bit          sched_en;
    bit          used [SLOTS];
    bit          active [SLOTS];
    logic [1:0]  mode_of [SLOTS];
    logic [31:0] deadline [SLOTS];
    logic [31:0] reload [SLOTS];
    logic [15:0] cycles_left [SLOTS];

    t_event pending_events[$];
    t_row   rows[$];
    int     errors = 0;
    int     hold_left = 0;
    int     stall_left = 0;
    bit     quiet = 0;

    function automatic logic [4:0] free_count();
        int n;
        n = 0;
        for (int k = 0; k < SLOTS; k++) if (!used[k]) n++;
        return n[4:0];
    endfunction

    function automatic void push_event(logic kind, logic [4:0] slot);
        t_event e;
        e.kind = kind;
        e.slot = slot;
        e.free = free_count();
        e.last = 0;
        pending_events.push_back(e);
    endfunction

    function automatic void predict_events(t_request r);
        int  n;
        bit  fire;
        n = 0;
        if (r.req == REQ_TICK) begin
            tick_cnt = tick_cnt + 32'd1;
            if (sched_en) begin
                for (int k = 0; k < SLOTS; k++) begin
                    fire = 0;
                    if (used[k] && active[k]) begin
                        case (mode_of[k])
                            MODE_SINGLE: if (tick_cnt >= deadline[k]) begin
                                used[k] = 0;
                                fire = 1;
                            end
                            MODE_REPEATED: if (tick_cnt >= deadline[k]) begin
                                deadline[k] = tick_cnt + reload[k];
                                fire = 1;
                            end
                            MODE_CYCLED: if (tick_cnt >= deadline[k]) begin
                                cycles_left[k] = cycles_left[k] - 16'd1;
                                if (cycles_left[k] != 0) deadline[k] = tick_cnt + reload[k];
                                else used[k] = 0;
                                fire = 1;
                            end
                            default: if (r.rtc >= deadline[k]) begin
                                used[k] = 0;
                                fire = 1;
                            end
                        endcase
                    end
                    if (fire) begin
                        push_event(1'b1, 5'(k + 1));
                        n++;
                    end
                end
            end
            if (n == 0) push_event(1'b0, 5'd0);
        end else if (r.req == REQ_ADD) begin
            logic [4:0] id;
            id = '0;
            for (int k = 0; k < SLOTS; k++) begin
                if (!used[k] && id == 0) begin
                    used[k] = 1;
                    active[k] = 1;
                    mode_of[k] = r.mode;
                    deadline[k] = (r.mode == MODE_ABSOLUTE) ? r.dt : tick_cnt + r.dt;
                    reload[k] = (r.mode == MODE_SINGLE) ? 32'd0 : r.dt;
                    if (r.mode == MODE_CYCLED) cycles_left[k] = r.reps;
                    id = 5'(k + 1);
                end
            end
            push_event(1'b0, id);
        end else begin
            if (r.sid >= 1 && r.sid <= SLOTS) begin
                if (r.req == REQ_REMOVE) used[r.sid - 1] = 0;
                else if (r.req == REQ_SUSPEND) active[r.sid - 1] = 0;
                else if (r.req == REQ_RESUME) active[r.sid - 1] = 1;
            end
            push_event(1'b0, 5'd0);
        end
        pending_events[$].last = 1;
    endfunction

    task automatic send_request(t_request r, bit typed, t_event ev);
        int n_prior;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {1'b0, r.rtc, r.sid, r.reps, r.dt, r.mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_prior = pending_events.size();
        predict_events(r);
        if (typed) begin
            while (pending_events.size() > n_prior) void'(pending_events.pop_back());
            pending_events.push_back(ev);
        end
    endtask

    task automatic drain_and_idle();
        @(posedge i_clk);
        s_axis_tvalid <= 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic write_enable(bit v);
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 0;
        sched_en = v;
        @(posedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(0, 99);
        r.mode = 2'($urandom_range(0, 3));
        r.dt   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) r.dt = 32'hFFFF_FFFF - $urandom_range(0, 2);
        r.reps = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        r.sid  = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, SLOTS));
        r.rtc  = ($urandom_range(0, 2) == 0) ? $urandom : tick_cnt + $urandom_range(0, 8);
        if (pick < 40) r.req = REQ_TICK;
        else if (pick < 70) r.req = REQ_ADD;
        else if (pick < 80) r.req = REQ_REMOVE;
        else if (pick < 87) r.req = REQ_SUSPEND;
        else if (pick < 94) r.req = REQ_RESUME;
        else r.req = 3'($urandom_range(5, 7));
        return r;
    endfunction

    function automatic void add_row(logic [2:0] req, logic [1:0] mode, logic [31:0] dt,
                                    logic [15:0] reps, logic [4:0] sid, logic [31:0] rtc,
                                    bit typed, logic k, logic [4:0] s, logic [4:0] f);
        t_row w;
        w.rq = '{req, mode, dt, reps, sid, rtc};
        w.typed = typed;
        w.ev = '{k, s, f, 1'b1};
        rows.push_back(w);
    endfunction

    // result checker and receiver-side stalls
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            t_event e;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer slot=%0d", m_axis_tdata[4:0]);
            end else begin
                e = pending_events.pop_front();
                if (m_axis_tuser !== e.kind || m_axis_tdata[4:0] !== e.slot ||
                    m_axis_tdata[9:5] !== e.free || m_axis_tdata[15:10] !== 6'd0 ||
                    m_axis_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp kind=%0d slot=%0d free=%0d last=%0d, ",
                                  "got kind=%0d slot=%0d free=%0d last=%0d data=%h"},
                                 e.kind, e.slot, e.free, e.last, m_axis_tuser,
                                 m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tlast,
                                 m_axis_tdata);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    initial begin
        t_request r;
        t_event   none;
        none = '{0, 0, 0, 0};
        tick_cnt = 0;
        sched_en = 1;
        for (int k = 0; k < SLOTS; k++) begin
            used[k] = 0; active[k] = 0; mode_of[k] = 0;
            deadline[k] = 0; reload[k] = 0; cycles_left[k] = 0;
        end

        add_row(REQ_TICK, 0, 0, 0, 0, 0, 1, 0, 0, 16);
        add_row(REQ_ADD, MODE_SINGLE, 0, 0, 0, 0, 1, 0, 1, 15);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 1, 1, 1, 16);
        add_row(REQ_ADD, MODE_REPEATED, 3, 0, 0, 0, 1, 0, 1, 15);
        add_row(REQ_ADD, MODE_CYCLED, 1, 16'd0, 0, 0, 1, 0, 2, 14);
        add_row(REQ_ADD, MODE_ABSOLUTE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 1, 0, 3, 13);
        add_row(REQ_REMOVE, 3, 32'hFFFF_FFFF, 0, 5'd0, 0, 1, 0, 0, 13);
        add_row(REQ_REMOVE, 0, 0, 0, 5'd31, 32'hFFFF_FFFF, 1, 0, 0, 13);
        add_row(REQ_SUSPEND, 0, 0, 0, 5'd1, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(REQ_RESUME, 0, 0, 0, 5'd1, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_SUSPEND, 0, 0, 0, 5'd16, 0, 0, 0, 0, 0);
        add_row(REQ_RESUME, 0, 0, 0, 5'd16, 0, 0, 0, 0, 0);
        add_row(REQ_SUSPEND, 0, 0, 0, 5'd2, 0, 0, 0, 0, 0);
        add_row(REQ_REMOVE, 0, 0, 0, 5'd2, 0, 0, 0, 0, 0);
        add_row(REQ_ADD, MODE_SINGLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_ADD, MODE_CYCLED, 0, 16'd2, 0, 0, 0, 0, 0, 0);
        add_row(3'd7, 3, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].ev);
        drain_and_idle();

        // fill the table, then one add past full, then many firings at once
        for (int i = 0; i < SLOTS + 1; i++) begin
            r = '{REQ_ADD, 2'($urandom_range(0, 2)), 32'($urandom_range(0, 2)),
                  16'($urandom_range(1, 3)), 0, $urandom};
            send_request(r, 0, none);
        end
        hold_left = 300;
        for (int i = 0; i < 4; i++) begin
            r = '{REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF};
            send_request(r, 0, none);
        end
        drain_and_idle();

        write_enable(0);
        for (int i = 0; i < 20; i++) send_request(random_request(), 0, none);
        drain_and_idle();

        write_enable(1);
        for (int i = 0; i < 55; i++) begin
            if (i == 40) quiet = 1;
            send_request(random_request(), 0, none);
        end
        drain_and_idle();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
